@@ src/spd_pkg.sv @@
`timescale 1ns / 1ps
// Shared types, constants and the CRC-16 byte step for the serial packet deframer.
// Depends on nothing; every other file of the block imports it.
package spd_pkg;

    // Field widths of the byte stream, the registers and the frame state.
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 16;
    localparam int TOTAL_W  = 17;
    localparam int CRC_W    = 16;
    localparam int OVH_W    = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Frame layout: three start bytes, two length bytes, one descriptor byte.
    localparam logic [LEN_W-1:0]   POS_START_A = LEN_W'(0);
    localparam logic [LEN_W-1:0]   POS_START_B = LEN_W'(1);
    localparam logic [LEN_W-1:0]   POS_START_C = LEN_W'(2);
    localparam logic [LEN_W-1:0]   POS_LEN_LO  = LEN_W'(3);
    localparam logic [LEN_W-1:0]   POS_LEN_HI  = LEN_W'(4);
    localparam logic [LEN_W-1:0]   POS_DESC    = LEN_W'(5);
    localparam logic [LEN_W-1:0]   POS_PAYLOAD = LEN_W'(6);
    localparam logic [CRC_W-1:0]   CRC_INIT    = CRC_W'(16'h00ff);

    // Register reset values.
    localparam logic [BYTE_W-1:0]  RST_START_A  = BYTE_W'(62);
    localparam logic [BYTE_W-1:0]  RST_START_B  = BYTE_W'(42);
    localparam logic [BYTE_W-1:0]  RST_START_C  = BYTE_W'(62);
    localparam logic [OVH_W-1:0]   RST_OVERHEAD = OVH_W'(11);
    localparam logic [LEN_W-1:0]   RST_MAX_BYTES = LEN_W'(256);

    // Frame status reported with every result.
    typedef enum logic [STATUS_W-1:0] {
        ST_IN_PROGRESS = 3'd0,
        ST_BAD_START   = 3'd1,
        ST_BAD_LENGTH  = 3'd2,
        ST_BAD_DESC    = 3'd3,
        ST_BAD_CRC     = 3'd4,
        ST_FRAME_OK    = 3'd5
    } t_status;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_A   = 3'd0,
        CFG_START_B   = 3'd1,
        CFG_START_C   = 3'd2,
        CFG_OVERHEAD  = 3'd3,
        CFG_MAX_BYTES = 3'd4
    } t_cfg_idx;

    // Current register contents, handed from the register file to the core.
    typedef struct packed {
        logic [BYTE_W-1:0] start_a;
        logic [BYTE_W-1:0] start_b;
        logic [BYTE_W-1:0] start_c;
        logic [OVH_W-1:0]  overhead;
        logic [LEN_W-1:0]  max_bytes;
    } t_cfg;

    // One result request.
    typedef struct packed {
        t_status           status;
        logic [BYTE_W-1:0] payload_byte;
        logic              payload_valid;
        logic [BYTE_W-1:0] descriptor;
        logic [LEN_W-1:0]  payload_length;
        logic [LEN_W-1:0]  frame_bytes;
    } t_result;

    // One byte of the reflected CCITT CRC-16.
    function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] d;
        logic [BYTE_W-1:0] e;
        d = b ^ crc[BYTE_W-1:0];
        e = d ^ {d[3:0], 4'b0000};
        crc_step = {e, crc[CRC_W-1:BYTE_W]}
                 ^ {12'b0, e[7:4]}
                 ^ {5'b0, e, 3'b000};
    endfunction

endpackage

@@ src/spd_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces of the deframer: received bytes, results and
// register writes. Depends on spd_pkg for field widths and types.

// Received byte channel.
interface spd_rx_if import spd_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface spd_res_if import spd_pkg::*;;
    logic              valid;
    logic              ready;
    t_status           status;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic [BYTE_W-1:0] descriptor;
    logic [LEN_W-1:0]  payload_length;
    logic [LEN_W-1:0]  frame_bytes;
    modport source (output valid, output status, output payload_byte,
                    output payload_valid, output descriptor,
                    output payload_length, output frame_bytes, input ready);
    modport sink   (input valid, input status, input payload_byte,
                    input payload_valid, input descriptor,
                    input payload_length, input frame_bytes, output ready);
endinterface

// Register write channel.
interface spd_cfg_if import spd_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ src/spd_cfg_regs.sv @@
`timescale 1ns / 1ps
// Configuration register file of the deframer: start string, overhead, size limit.
// Depends on spd_pkg and the spd_cfg_if write channel.
module spd_cfg_regs import spd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spd_cfg_if.sink   i_cfg,
    output t_cfg      o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Writes are always taken; unknown indexes are dropped.
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_START_A:   n_cfg.start_a   = i_cfg.data[BYTE_W-1:0];
                CFG_START_B:   n_cfg.start_b   = i_cfg.data[BYTE_W-1:0];
                CFG_START_C:   n_cfg.start_c   = i_cfg.data[BYTE_W-1:0];
                CFG_OVERHEAD:  n_cfg.overhead  = i_cfg.data[OVH_W-1:0];
                CFG_MAX_BYTES: n_cfg.max_bytes = i_cfg.data[LEN_W-1:0];
                default:       n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_a   <= RST_START_A;
            r_cfg.start_b   <= RST_START_B;
            r_cfg.start_c   <= RST_START_C;
            r_cfg.overhead  <= RST_OVERHEAD;
            r_cfg.max_bytes <= RST_MAX_BYTES;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

@@ src/spd_core.sv @@
`timescale 1ns / 1ps
// Frame tracking core: byte position, length, descriptor, running CRC and the
// received checksum, with the result of one byte. Depends on spd_pkg.
module spd_core import spd_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  t_cfg              i_cfg,
    output t_result           o_res
);

    logic [LEN_W-1:0]   r_count,    n_count;
    logic [TOTAL_W-1:0] r_total,    n_total;
    logic [LEN_W-1:0]   r_length,   n_length;
    logic [BYTE_W-1:0]  r_desc,     n_desc;
    logic [CRC_W-1:0]   r_crc,      n_crc;
    logic [CRC_W-1:0]   r_rx_chk,   n_rx_chk;

    logic [TOTAL_W-1:0] w_count_x;
    logic [TOTAL_W-1:0] w_next;
    logic [TOTAL_W-1:0] w_chk_pos;
    logic [TOTAL_W-1:0] w_total_new;
    logic [BYTE_W-1:0]  w_want;
    t_result            w_res;

    assign w_count_x   = {1'b0, r_count};
    assign w_next      = w_count_x + TOTAL_W'(1);
    assign w_chk_pos   = {1'b0, r_length} + {1'b0, POS_PAYLOAD};
    assign w_total_new = {1'b0, r_length} + TOTAL_W'(i_cfg.overhead);

    // Expected start byte for the current position.
    always_comb begin
        if (r_count == POS_START_A) begin
            w_want = i_cfg.start_a;
        end else if (r_count == POS_START_B) begin
            w_want = i_cfg.start_b;
        end else begin
            w_want = i_cfg.start_c;
        end
    end

    // Next frame state and the result of the byte at the input.
    always_comb begin
        n_count  = r_count;
        n_total  = r_total;
        n_length = r_length;
        n_desc   = r_desc;
        n_crc    = r_crc;
        n_rx_chk = r_rx_chk;
        w_res.status        = ST_IN_PROGRESS;
        w_res.payload_byte  = '0;
        w_res.payload_valid = 1'b0;
        w_res.frame_bytes   = '0;

        if (r_count < POS_LEN_LO) begin
            // Start string: a mismatch drops back to the first start byte.
            if (i_byte != w_want) begin
                n_count      = '0;
                w_res.status = ST_BAD_START;
            end else begin
                n_count = r_count + LEN_W'(1);
            end
        end else if (r_count == POS_LEN_LO) begin
            n_length = {{(LEN_W-BYTE_W){1'b0}}, i_byte};
            n_count  = POS_LEN_HI;
        end else if (r_count == POS_LEN_HI) begin
            n_length = {i_byte, r_length[BYTE_W-1:0]};
            n_count  = POS_DESC;
        end else if (r_count == POS_DESC) begin
            // Frame size is fixed here; an oversize frame loses the descriptor.
            n_total = w_total_new;
            if (w_total_new > {1'b0, i_cfg.max_bytes}) begin
                n_count      = '0;
                w_res.status = ST_BAD_LENGTH;
            end else begin
                n_desc   = i_byte;
                n_count  = POS_PAYLOAD;
                n_crc    = CRC_INIT;
                n_rx_chk = '0;
                if ({{(LEN_W-BYTE_W){1'b0}}, i_byte} > i_cfg.max_bytes) begin
                    n_count      = '0;
                    w_res.status = ST_BAD_DESC;
                end
            end
        end else begin
            // Payload, checksum and stop bytes.
            if (w_count_x < w_chk_pos) begin
                w_res.payload_byte  = i_byte;
                w_res.payload_valid = 1'b1;
                n_crc = crc_step(r_crc, i_byte);
            end else if (w_count_x == w_chk_pos) begin
                n_rx_chk = {r_rx_chk[CRC_W-1:BYTE_W], i_byte};
            end else if (w_count_x == w_chk_pos + TOTAL_W'(1)) begin
                n_rx_chk = {i_byte, r_rx_chk[BYTE_W-1:0]};
            end
            n_count = w_next[LEN_W-1:0];
            if (w_next >= r_total) begin
                n_count = '0;
                if (n_crc != n_rx_chk) begin
                    w_res.status = ST_BAD_CRC;
                end else begin
                    w_res.status      = ST_FRAME_OK;
                    w_res.frame_bytes = w_next[LEN_W-1:0];
                end
            end
        end

        w_res.descriptor     = n_desc;
        w_res.payload_length = n_length;
    end

    // The comparison above includes this byte, so a frame may end on its last
    // checksum byte or, with a short overhead, on a payload byte.

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_total  <= '0;
            r_length <= '0;
            r_desc   <= '0;
            r_crc    <= CRC_INIT;
            r_rx_chk <= '0;
        end else if (i_step) begin
            r_count  <= n_count;
            r_total  <= n_total;
            r_length <= n_length;
            r_desc   <= n_desc;
            r_crc    <= n_crc;
            r_rx_chk <= n_rx_chk;
        end
    end

    assign o_res = w_res;

endmodule

@@ src/serial_packet_deframer_crc16.sv @@
`timescale 1ns / 1ps
// Top level of the serial packet deframer with CRC-16 check.
// Depends on spd_pkg, spd_if, spd_cfg_regs and spd_core.
//
// Usage:
//  i_rx carries one received byte per request. Each accepted byte gives
//  exactly one request on o_res: status, the payload byte with its valid
//  flag, the current descriptor and length fields, and the frame size on
//  a good frame.
//  i_cfg writes the start string, frame overhead and size limit; it is
//  always ready and should only be used while no byte is in flight.
//  A byte accepted into the input register has its result registered in
//  the output register as soon as that register is free.
//  Throughput: one byte per cycle while the sink keeps up, set by the single
//  pass of frame logic between the input register and the output register.
//  Reset (synchronous, active low) empties both registers, clears the
//  frame state and restores the register defaults.
//  When the sink stalls, the output register holds its result, the input
//  register holds one more byte, and i_rx.ready drops until space frees.
module serial_packet_deframer_crc16 import spd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    spd_rx_if.sink    i_rx,
    spd_cfg_if.sink   i_cfg,
    spd_res_if.source o_res
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              w_advance;
    logic              w_in_take;
    t_cfg              w_cfg;
    t_result           w_res;

    // Handshake: the input stage moves on when the output register is free.
    assign w_advance  = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;
    assign w_in_take  = i_rx.valid && i_rx.ready;

    spd_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    spd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_advance),
        .i_byte  (r_in_byte),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_take) begin
            r_in_valid <= 1'b1;
        end else if (w_advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_res.valid          = r_out_valid;
    assign o_res.status         = r_out.status;
    assign o_res.payload_byte   = r_out.payload_byte;
    assign o_res.payload_valid  = r_out.payload_valid;
    assign o_res.descriptor     = r_out.descriptor;
    assign o_res.payload_length = r_out.payload_length;
    assign o_res.frame_bytes    = r_out.frame_bytes;

endmodule

@@ tb/spd_deframer_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the serial packet deframer: it watches the byte, register
// and result channels, predicts each result and compares it with the DUT output.
// Depends on spd_pkg and on the channel interfaces of spd_if.
module spd_deframer_checker import spd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    spd_rx_if    i_rx,
    spd_cfg_if   i_cfg,
    spd_res_if   i_res,
    output int   o_errors,
    output int   o_pending
);

    localparam int               REPORT_LIMIT    = 10;
    localparam logic [CRC_W-1:0] CCITT_POLY_REFL = 16'h8408;

    // This is the checker's own copy of the registers.
    logic [BYTE_W-1:0] want_a    = RST_START_A;
    logic [BYTE_W-1:0] want_b    = RST_START_B;
    logic [BYTE_W-1:0] want_c    = RST_START_C;
    logic [OVH_W-1:0]  overhead  = RST_OVERHEAD;
    logic [LEN_W-1:0]  max_bytes = RST_MAX_BYTES;

    // This is the frame state as it should stand after each byte.
    logic [LEN_W-1:0]   frame_pos   = '0;
    logic [TOTAL_W-1:0] frame_total = '0;
    logic [LEN_W-1:0]   length_f    = '0;
    logic [BYTE_W-1:0]  desc_f      = '0;
    logic [CRC_W-1:0]   crc_acc     = CRC_INIT;
    logic [CRC_W-1:0]   crc_rcvd    = '0;

    t_result expected_results[$];
    int      mismatches = 0;

    assign o_errors = mismatches;

    // This is the reflected CCITT CRC, worked out one bit at a time.
    function automatic logic [CRC_W-1:0] crc_ccitt_byte(input logic [CRC_W-1:0] crc,
                                                        input logic [BYTE_W-1:0] b);
        logic [CRC_W-1:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < BYTE_W; i++)
            c = c[0] ? ((c >> 1) ^ CCITT_POLY_REFL) : (c >> 1);
        return c;
    endfunction

    // Advance the frame state by one received byte and return the result it gives.
    function automatic t_result deframe_byte(input logic [BYTE_W-1:0] b);
        t_result            r;
        logic [BYTE_W-1:0]  want;
        logic [TOTAL_W-1:0] chk_pos;
        logic [TOTAL_W-1:0] nxt;
        r = '0;
        r.status = ST_IN_PROGRESS;
        if (frame_pos < 3) begin
            want = (frame_pos == POS_START_A) ? want_a :
                   (frame_pos == POS_START_B) ? want_b : want_c;
            if (b != want) begin
                frame_pos = '0;
                r.status  = ST_BAD_START;
            end else begin
                frame_pos = frame_pos + 1'b1;
            end
        end else if (frame_pos == POS_LEN_LO) begin
            length_f  = {8'h00, b};
            frame_pos = POS_LEN_HI;
        end else if (frame_pos == POS_LEN_HI) begin
            length_f[15:8] = b;
            frame_pos      = POS_DESC;
        end else if (frame_pos == POS_DESC) begin
            // The frame size is fixed here, from the overhead in force now.
            frame_total = {1'b0, length_f} + {13'b0, overhead};
            if (frame_total > {1'b0, max_bytes}) begin
                frame_pos = '0;
                r.status  = ST_BAD_LENGTH;
            end else begin
                desc_f    = b;
                frame_pos = POS_PAYLOAD;
                crc_acc   = CRC_INIT;
                crc_rcvd  = '0;
                if ({8'h00, b} > max_bytes) begin
                    frame_pos = '0;
                    r.status  = ST_BAD_DESC;
                end
            end
        end else begin
            chk_pos = {1'b0, length_f} + {1'b0, POS_PAYLOAD};
            nxt     = {1'b0, frame_pos} + 1'b1;
            if ({1'b0, frame_pos} < chk_pos) begin
                r.payload_byte  = b;
                r.payload_valid = 1'b1;
                crc_acc         = crc_ccitt_byte(crc_acc, b);
            end else if ({1'b0, frame_pos} == chk_pos) begin
                crc_rcvd[7:0] = b;
            end else if ({1'b0, frame_pos} == chk_pos + 1'b1) begin
                crc_rcvd[15:8] = b;
            end
            frame_pos = nxt[LEN_W-1:0];
            if (nxt >= frame_total) begin
                frame_pos = '0;
                if (crc_acc != crc_rcvd) begin
                    r.status = ST_BAD_CRC;
                end else begin
                    r.status      = ST_FRAME_OK;
                    r.frame_bytes = nxt[LEN_W-1:0];
                end
            end
        end
        r.descriptor     = desc_f;
        r.payload_length = length_f;
        return r;
    endfunction

    // Follow register writes, accepted bytes and returned results at each edge.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            want_a      = RST_START_A;
            want_b      = RST_START_B;
            want_c      = RST_START_C;
            overhead    = RST_OVERHEAD;
            max_bytes   = RST_MAX_BYTES;
            frame_pos   = '0;
            frame_total = '0;
            length_f    = '0;
            desc_f      = '0;
            crc_acc     = CRC_INIT;
            crc_rcvd    = '0;
            expected_results.delete();
        end else begin
            // A register write lands only in its own field width.
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_START_A:   want_a    = i_cfg.data[BYTE_W-1:0];
                    CFG_START_B:   want_b    = i_cfg.data[BYTE_W-1:0];
                    CFG_START_C:   want_c    = i_cfg.data[BYTE_W-1:0];
                    CFG_OVERHEAD:  overhead  = i_cfg.data[OVH_W-1:0];
                    CFG_MAX_BYTES: max_bytes = i_cfg.data[LEN_W-1:0];
                    default: ;
                endcase
            end

            // A returned result must match the oldest request still waiting.
            if (i_res.valid && i_res.ready) begin
                got.status         = i_res.status;
                got.payload_byte   = i_res.payload_byte;
                got.payload_valid  = i_res.payload_valid;
                got.descriptor     = i_res.descriptor;
                got.payload_length = i_res.payload_length;
                got.frame_bytes    = i_res.frame_bytes;
                if (expected_results.size() == 0) begin
                    if (mismatches < REPORT_LIMIT)
                        $display("%0t: result with no byte waiting: status %0d frame %0d",
                                 $time, got.status, got.frame_bytes);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (mismatches < REPORT_LIMIT)
                            $display({"%0t: result mismatch (exp/got): status %0d/%0d ",
                                      "payload %h,%b/%h,%b desc %h/%h length %h/%h ",
                                      "frame %0d/%0d"}, $time,
                                     want.status, got.status,
                                     want.payload_byte, want.payload_valid,
                                     got.payload_byte, got.payload_valid,
                                     want.descriptor, got.descriptor,
                                     want.payload_length, got.payload_length,
                                     want.frame_bytes, got.frame_bytes);
                        mismatches++;
                    end
                end
            end

            // Each accepted byte owes exactly one result.
            if (i_rx.valid && i_rx.ready)
                expected_results.push_back(deframe_byte(i_rx.rx_byte));
        end
        o_pending <= expected_results.size();
    end

endmodule

@@ tb/tb_serial_packet_deframer_crc16.sv @@
`timescale 1ns / 1ps
// Testbench top for the serial packet deframer: it drives framed, broken and
// noisy byte streams under several register settings and gives the verdict.
// Depends on spd_pkg, spd_if, the deframer RTL and spd_deframer_checker.
module tb_serial_packet_deframer_crc16 import spd_pkg::*;;

    localparam int HALF_PERIOD   = 6;
    localparam int RESET_CYCLES  = 10;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS    = 10_000_000;

    typedef enum logic [1:0] {
        SINK_OPEN,
        SINK_LIGHT,
        SINK_HEAVY,
        SINK_BEAT
    } t_sink_mode;

    logic       clk;
    logic       rst_n      = 1'b0;
    logic       sink_ready = 1'b0;
    t_sink_mode sink_mode  = SINK_OPEN;
    int         sink_span  = 0;
    logic [3:0] sink_beat  = '0;
    int         errors;
    int         pending;

    // These are the register values the stimulus builds frames for.
    logic [BYTE_W-1:0] cur_a   = RST_START_A;
    logic [BYTE_W-1:0] cur_b   = RST_START_B;
    logic [BYTE_W-1:0] cur_c   = RST_START_C;
    logic [OVH_W-1:0]  cur_ovh = RST_OVERHEAD;
    logic [LEN_W-1:0]  cur_max = RST_MAX_BYTES;

    int burst_left = 0;
    bit steady     = 1'b0;
    int bytes_sent = 0;

    spd_rx_if  rx_ch ();
    spd_res_if res_ch ();
    spd_cfg_if cfg_ch ();

    assign res_ch.ready = sink_ready;

    serial_packet_deframer_crc16 uut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_ch),
        .i_cfg   (cfg_ch),
        .o_res   (res_ch)
    );

    spd_deframer_checker chk (
        .i_clk     (clk),
        .i_rst_n   (rst_n),
        .i_rx      (rx_ch),
        .i_cfg     (cfg_ch),
        .i_res     (res_ch),
        .o_errors  (errors),
        .o_pending (pending)
    );

    initial begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // The result side switches between stall patterns of random length.
    always @(posedge clk) begin
        if (sink_span == 0) begin
            sink_mode <= t_sink_mode'($urandom_range(0, 3));
            sink_span <= $urandom_range(16, 200);
        end else begin
            sink_span <= sink_span - 1;
        end
        sink_beat <= sink_beat + 1'b1;
        case (sink_mode)
            SINK_OPEN:  sink_ready <= 1'b1;
            SINK_LIGHT: sink_ready <= ($urandom_range(0, 3) != 0);
            SINK_HEAVY: sink_ready <= ($urandom_range(0, 3) == 0);
            default:    sink_ready <= sink_beat[2];
        endcase
    end

    // Send one byte request; bursts of random length are split by random gaps.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = steady ? 0 : $urandom_range(0, 7);
            if (gap > 0) begin
                rx_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        rx_ch.valid   <= 1'b1;
        rx_ch.rx_byte <= b;
        do @(posedge clk); while (!rx_ch.ready);
        bytes_sent++;
    endtask

    // Send a frame as the current registers expect it; a rejected header
    // ends the frame, so nothing is sent after the descriptor then.
    task automatic send_frame(input logic [LEN_W-1:0] len, input logic [BYTE_W-1:0] desc,
                              input bit bad_crc);
        int                unsigned total;
        int                unsigned last;
        logic [CRC_W-1:0]  crc;
        logic [CRC_W-1:0]  chk_word;
        logic [BYTE_W-1:0] b;
        total = int'(len) + int'(cur_ovh);
        send_byte(cur_a);
        send_byte(cur_b);
        send_byte(cur_c);
        send_byte(len[7:0]);
        send_byte(len[15:8]);
        send_byte(desc);
        if (total > cur_max || desc > cur_max)
            return;
        last = (total < 7) ? 7 : total;
        crc = CRC_INIT;
        chk_word = '0;
        for (int i = 6; i < last; i++) begin
            if (i < 6 + int'(len)) begin
                b = 8'($urandom);
                crc = crc_step(crc, b);
            end else if (i == 6 + int'(len)) begin
                chk_word = bad_crc ? crc ^ 16'($urandom_range(1, 16'hffff)) : crc;
                b = chk_word[7:0];
            end else if (i == 7 + int'(len)) begin
                b = chk_word[15:8];
            end else begin
                b = 8'($urandom);
            end
            send_byte(b);
        end
    endtask

    // Mostly well-formed frames with random content, the rest oversized
    // lengths, stray bytes and start strings that break off.
    task automatic random_traffic(input int n);
        int                stop_at;
        int                kind;
        int                room;
        int                reach;
        int                desc_top;
        logic [LEN_W-1:0]  len;
        logic [BYTE_W-1:0] desc;
        stop_at  = bytes_sent + n;
        room     = int'(cur_max) - int'(cur_ovh);
        desc_top = (cur_max > 16'd255) ? 255 : int'(cur_max);
        while (bytes_sent < stop_at) begin
            if ($urandom_range(0, 24) == 0) begin
                // Hold the sender until every request in flight has come back.
                rx_ch.valid <= 1'b0;
                do @(posedge clk); while (pending != 0);
            end
            kind = $urandom_range(0, 99);
            if (kind < 72 && room >= 0) begin
                reach = (room > 24) ? 24 : room;
                if ($urandom_range(0, 9) == 0)
                    reach = (room > 300) ? 300 : room;
                len = 16'($urandom_range(0, reach));
                if (cur_max < 16'd255 && $urandom_range(0, 4) == 0)
                    desc = 8'($urandom);
                else
                    desc = 8'($urandom_range(0, desc_top));
                send_frame(len, desc, $urandom_range(0, 6) == 0);
            end else if (kind < 80 && room < 16'hffff) begin
                len = 16'($urandom_range((room < 0) ? 0 : room + 1, 16'hffff));
                send_frame(len, 8'($urandom), 1'b0);
            end else if (kind < 92) begin
                repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
            end else begin
                send_byte(cur_a);
                if ($urandom_range(0, 1) == 1)
                    send_byte(cur_b);
                repeat ($urandom_range(0, 3)) send_byte(8'($urandom));
            end
        end
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
    endtask

    // Write all five registers; unused upper data bits carry random values.
    task automatic set_config(input logic [BYTE_W-1:0] a, input logic [BYTE_W-1:0] b,
                              input logic [BYTE_W-1:0] c, input logic [OVH_W-1:0] ovh,
                              input logic [LEN_W-1:0] maxb);
        write_reg(CFG_START_A, {8'($urandom), a});
        write_reg(CFG_START_B, {8'($urandom), b});
        write_reg(CFG_START_C, {8'($urandom), c});
        write_reg(CFG_OVERHEAD, {12'($urandom), ovh});
        write_reg(CFG_MAX_BYTES, maxb);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
        cur_a   = a;
        cur_b   = b;
        cur_c   = c;
        cur_ovh = ovh;
        cur_max = maxb;
    endtask

    // Stop sending and wait until every result is back and the block is quiet.
    task automatic settle();
        rx_ch.valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial begin
        rx_ch.valid   <= 1'b0;
        rx_ch.rx_byte <= '0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.index  <= CFG_START_A;
        cfg_ch.data   <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a bad start byte, a short good frame, an oversized length.
        send_byte(8'h00);
        send_frame(16'd1, 8'hff, 1'b0);
        send_frame(16'hffff, 8'h00, 1'b0);
        random_traffic(150);
        settle();

        // The widest size limit; the length plus overhead needs the 17th bit.
        set_config(8'h00, 8'hff, 8'h00, 4'd8, 16'hffff);
        steady = 1'b1;
        send_frame(16'hffff, 8'h01, 1'b0);
        random_traffic(120);
        steady = 1'b0;
        settle();

        // The smallest size limit: only empty frames pass, descriptors above 8 fail.
        set_config(8'hff, 8'h55, 8'haa, 4'd8, 16'd8);
        send_frame(16'd0, 8'hff, 1'b0);
        random_traffic(80);
        settle();

        // The largest overhead, which adds several stop bytes.
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 4'd15, 16'd300);
        random_traffic(120);
        settle();

        // No overhead at all: frames end early, before the checksum is complete.
        set_config(8'($urandom), 8'($urandom), 8'($urandom), 4'd0,
                   16'($urandom_range(40, 600)));
        random_traffic(80);
        settle();

        // An overhead of five, so every frame with a payload ends on a payload byte.
        set_config(RST_START_A, RST_START_B, RST_START_C, 4'd5, RST_MAX_BYTES);
        random_traffic(60);
        settle();

        if (errors == 0 && pending == 0)
            $display("serial_packet_deframer_crc16 test passed");
        else
            $display("serial_packet_deframer_crc16 test failed");
        $finish;
    end

    // This is a hard limit, far above the slowest correct run.
    initial begin
        #TIMEOUT_NS;
        $display("serial_packet_deframer_crc16 test failed");
        $finish;
    end

endmodule
